/* rtl/core/dnd_pkg.sv */
package dnd_pkg;

	localparam int MSG_BYTES = 1024;
	localparam int MAX_NAME  = 256;
	localparam int ADDR_W    = $clog2(MSG_BYTES);

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_OVERFLOW  = 3'd1;
	localparam logic [2:0] ST_PTR_RANGE = 3'd2;
	localparam logic [2:0] ST_LOOP      = 3'd3;
	localparam logic [2:0] ST_RESERVED  = 3'd4;
	localparam logic [2:0] ST_PAST_END  = 3'd5;

	localparam logic [1:0] TOP_LABEL = 2'b00;
	localparam logic [1:0] TOP_PTR   = 2'b11;

	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_BSL = 8'h5c;

	typedef struct packed {
		logic        action;
		logic [9:0]  load_addr;
		logic [7:0]  load_byte;
		logic [9:0]  start_offset;
		logic [10:0] msg_length;
		logic [8:0]  out_capacity;
	} req_t;

	typedef struct packed {
		logic [63:0] out_chars;
		logic [3:0]  out_count;
		logic        is_last;
		logic [2:0]  status;
		logic [10:0] consumed;
	} rsp_t;

	typedef struct packed {
		logic       init;
		logic       rd_len;
		logic       rd_ptr;
		logic       latch_n;
		logic       add_label;
		logic       dec_rem;
		logic       jump;
		logic       cons_term;
		logic       cons_ptr;
		logic       put_dot;
		logic       put_esc;
		logic       put_char;
		logic       flush;
		logic       emit_last;
		logic       set_st;
		logic [2:0] st;
	} cmd_t;

	typedef struct packed {
		logic       past_end;
		logic       n_zero;
		logic [1:0] n_top;
		logic       d_zero;
		logic       ovf_dot;
		logic       ovf_label;
		logic       is_dot;
		logic       ovf_esc;
		logic       ptr_range;
		logic       loop;
		logic       rem_zero;
		logic       chunk_full;
		logic       out_free;
	} stat_t;

endpackage

/* rtl/core/dns_name_decompressor.sv */
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | req_t: load byte or expand request
// rsp     | out       | rsp_valid, rsp_stall | rsp_t: text chunk, status on last
//
// a load writes one store byte; an expand stalls req for its walk: it reads each length
// byte and a pointer's low byte from the store, checks each label, puts a dot before
// every label after the first, then reads, checks and puts each character, with a
// backslash before a dot; each full chunk is sent as it fills, the final one at the close;
// under rsp_stall the walk waits once the chunk buffer is full and a waiting chunk is held
// arst_n clears the controller and the result valid flag; the store and result payload are not cleared
module dns_name_decompressor import dnd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t  cmd;
	stat_t stat;
	logic  req_fire;

	assign req_fire = req_valid && !req_stall;

	dnd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_fire   (req_fire),
		.req_action (req.action),
		.stat       (stat),
		.req_stall  (req_stall),
		.cmd        (cmd)
	);

	dnd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_fire  (req_fire),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

/* rtl/core/dnd_store.sv */
module dnd_store import dnd_pkg::*; (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [MSG_BYTES];

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/core/dnd_datapath.sv */
module dnd_datapath import dnd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_fire,
	input  req_t  req,
	input  cmd_t  cmd,
	output stat_t stat,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	output rsp_t  rsp
);

	logic [9:0]  start_q;
	logic [10:0] mlen_q;
	logic [8:0]  cap_q;
	logic [10:0] p_q;
	logic [8:0]  d_q;
	logic [11:0] chk_q;
	logic [10:0] cons_q;
	logic        have_cons_q;
	logic [5:0]  rem_q;
	logic [63:0] chunk_q;
	logic [3:0]  cnt_q;
	logic [2:0]  st_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic [7:0]  rd_data;
	logic [13:0] target;
	logic [10:0] mlen_sat;
	logic [8:0]  cap_sat;
	logic        put;
	logic [7:0]  put_byte;

	dnd_store u_store (
		.clk     (clk),
		.wr_en   (req_fire && !req.action),
		.wr_addr (req.load_addr),
		.wr_data (req.load_byte),
		.rd_en   (cmd.rd_len || cmd.rd_ptr),
		.rd_addr (p_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	assign mlen_sat = (req.msg_length > 11'(MSG_BYTES)) ? 11'(MSG_BYTES) : req.msg_length;
	assign cap_sat  = (req.out_capacity > 9'(MAX_NAME)) ? 9'(MAX_NAME) : req.out_capacity;

	// pointer high bits were parked in rem_q by the length step
	assign target = {rem_q, rd_data};

	assign put      = cmd.put_dot || cmd.put_esc || cmd.put_char;
	assign put_byte = cmd.put_dot ? CH_DOT : (cmd.put_esc ? CH_BSL : rd_data);

	// overflow tests use cap directly: d >= cap-1 is d+1 >= cap
	always_comb begin
		stat.past_end   = p_q >= mlen_q;
		stat.n_zero     = rd_data == 8'd0;
		stat.n_top      = rd_data[7:6];
		stat.d_zero     = d_q == 9'd0;
		stat.ovf_dot    = ({1'b0, d_q} + 10'd1) >= {1'b0, cap_q};
		stat.ovf_label  = ({1'b0, d_q} + {4'b0, rem_q} + 10'd1) >= {1'b0, cap_q};
		stat.is_dot     = rd_data == CH_DOT;
		stat.ovf_esc    = ({1'b0, d_q} + {4'b0, rem_q} + 10'd2) >= {1'b0, cap_q};
		stat.ptr_range  = target >= {3'b0, mlen_q};
		stat.loop       = (chk_q + 12'd2) >= {1'b0, mlen_q};
		stat.rem_zero   = rem_q == 6'd0;
		stat.chunk_full = cnt_q[3];
		stat.out_free   = !rsp_valid_q || !rsp_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			start_q     <= req.start_offset;
			mlen_q      <= mlen_sat;
			cap_q       <= cap_sat;
			p_q         <= {1'b0, req.start_offset};
			d_q         <= '0;
			chk_q       <= '0;
			cons_q      <= '0;
			have_cons_q <= 1'b0;
			chunk_q     <= '0;
			cnt_q       <= '0;
			st_q        <= ST_OK;
		end
		if (cmd.rd_len)
			p_q <= p_q + 11'd1;
		if (cmd.latch_n)
			rem_q <= rd_data[5:0];
		if (cmd.add_label)
			chk_q <= chk_q + {6'b0, rem_q} + 12'd1;
		if (cmd.dec_rem)
			rem_q <= rem_q - 6'd1;
		if (cmd.jump) begin
			chk_q <= chk_q + 12'd2;
			p_q   <= target[10:0];
		end
		if (cmd.cons_term && !have_cons_q)
			cons_q <= p_q - {1'b0, start_q};
		if (cmd.cons_ptr && !have_cons_q) begin
			cons_q      <= p_q - {1'b0, start_q} + 11'd1;
			have_cons_q <= 1'b1;
		end
		if (put) begin
			chunk_q[{cnt_q[2:0], 3'b000} +: 8] <= put_byte;
			cnt_q <= cnt_q + 4'd1;
			d_q   <= d_q + 9'd1;
		end
		if (cmd.flush) begin
			chunk_q <= '0;
			cnt_q   <= '0;
		end
		if (cmd.set_st)
			st_q <= cmd.st;
		if (cmd.flush || cmd.emit_last) begin
			rsp_q.out_chars <= chunk_q;
			rsp_q.out_count <= cnt_q;
			rsp_q.is_last   <= cmd.emit_last;
			rsp_q.status    <= cmd.emit_last ? st_q : ST_OK;
			rsp_q.consumed  <= (cmd.emit_last && st_q == ST_OK) ? cons_q : 11'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.flush || cmd.emit_last) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.put_dot || cmd.put_esc || cmd.put_char) |-> !cnt_q[3])
		else $error("character written into a full chunk");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.flush || cmd.emit_last) |-> (!rsp_valid_q || !rsp_stall))
		else $error("chunk emitted over a waiting result");

	a_full_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.is_last) |-> rsp_q.out_count == 4'd8)
		else $error("non-final chunk is not full");

	a_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.consumed != 11'd0) |-> (rsp_q.is_last && rsp_q.status == ST_OK))
		else $error("consumed set outside a successful final chunk");

	a_text_cap: assert property (@(posedge clk) disable iff (!arst_n)
		put |-> ({1'b0, d_q} + 10'd1) < {1'b0, cap_q})
		else $error("text grew past capacity");

endmodule

/* rtl/core/dnd_ctrl.sv */
module dnd_ctrl import dnd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_fire,
	input  logic  req_action,
	input  stat_t stat,
	output logic  req_stall,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LEN_RD,
		S_LEN,
		S_DOT,
		S_LABCHK,
		S_CH_RD,
		S_CH,
		S_ESC,
		S_PUTC,
		S_PTR_RD,
		S_PTR,
		S_FIN
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire && req_action) begin
					cmd.init = 1'b1;
					state_d  = S_LEN_RD;
				end
			end
			S_LEN_RD: begin
				if (stat.past_end) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_PAST_END;
					state_d    = S_FIN;
				end else begin
					cmd.rd_len = 1'b1;
					state_d    = S_LEN;
				end
			end
			S_LEN: begin
				if (stat.n_zero) begin
					cmd.cons_term = 1'b1;
					state_d       = S_FIN;
				end else begin
					case (stat.n_top)
						TOP_LABEL: begin
							cmd.latch_n = 1'b1;
							if (stat.d_zero) begin
								state_d = S_LABCHK;
							end else if (stat.ovf_dot) begin
								cmd.set_st = 1'b1;
								cmd.st     = ST_OVERFLOW;
								state_d    = S_FIN;
							end else begin
								state_d = S_DOT;
							end
						end
						TOP_PTR: begin
							// low six bits become the pointer high part
							cmd.latch_n  = 1'b1;
							cmd.cons_ptr = 1'b1;
							state_d      = S_PTR_RD;
						end
						default: begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_RESERVED;
							state_d    = S_FIN;
						end
					endcase
				end
			end
			S_DOT: begin
				if (stat.chunk_full) begin
					cmd.flush = stat.out_free;
				end else begin
					cmd.put_dot = 1'b1;
					state_d     = S_LABCHK;
				end
			end
			S_LABCHK: begin
				if (stat.ovf_label) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_OVERFLOW;
					state_d    = S_FIN;
				end else begin
					cmd.add_label = 1'b1;
					state_d       = S_CH_RD;
				end
			end
			S_CH_RD: begin
				if (stat.rem_zero) begin
					state_d = S_LEN_RD;
				end else begin
					cmd.dec_rem = 1'b1;
					if (stat.past_end) begin
						cmd.set_st = 1'b1;
						cmd.st     = ST_PAST_END;
						state_d    = S_FIN;
					end else begin
						cmd.rd_len = 1'b1;
						state_d    = S_CH;
					end
				end
			end
			S_CH: begin
				if (!stat.is_dot) begin
					state_d = S_PUTC;
				end else if (stat.ovf_esc) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_OVERFLOW;
					state_d    = S_FIN;
				end else begin
					state_d = S_ESC;
				end
			end
			S_ESC: begin
				if (stat.chunk_full) begin
					cmd.flush = stat.out_free;
				end else begin
					cmd.put_esc = 1'b1;
					state_d     = S_PUTC;
				end
			end
			S_PUTC: begin
				if (stat.chunk_full) begin
					cmd.flush = stat.out_free;
				end else begin
					cmd.put_char = 1'b1;
					state_d      = S_CH_RD;
				end
			end
			S_PTR_RD: begin
				if (stat.past_end) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_PAST_END;
					state_d    = S_FIN;
				end else begin
					cmd.rd_ptr = 1'b1;
					state_d    = S_PTR;
				end
			end
			S_PTR: begin
				if (stat.ptr_range) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_PTR_RANGE;
					state_d    = S_FIN;
				end else if (stat.loop) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_LOOP;
					state_d    = S_FIN;
				end else begin
					cmd.jump = 1'b1;
					state_d  = S_LEN_RD;
				end
			end
			S_FIN: begin
				// a full chunk left over goes out before the final one
				if (stat.out_free) begin
					if (stat.chunk_full) begin
						cmd.flush = 1'b1;
					end else begin
						cmd.emit_last = 1'b1;
						state_d       = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = state_q != S_IDLE;

endmodule
